@@ src/rom_song_region_locator_top_defines.svh @@
// Assertion macros for the song region locator.
`ifndef ROM_SONG_REGION_LOCATOR_TOP_DEFINES_SVH
`define ROM_SONG_REGION_LOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RSRL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsrl assertion failed");
`define RSRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsrl assertion failed");
`else
`define RSRL_ASSERT_SAME(label, ante, cons)
`define RSRL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/rsrl_pkg.sv @@
// Shared types and constants of the song region locator.
package rsrl_pkg;

  localparam int OUT_BITS = 24;

  localparam logic [1:0] OUTCOME_WHOLE     = 2'd0;
  localparam logic [1:0] OUTCOME_NO_REGION = 2'd1;
  localparam logic [1:0] OUTCOME_FOUND     = 2'd2;

  localparam logic [3:0][7:0] MAGIC = {8'h4D, 8'h52, 8'h45, 8'h00};

  localparam logic [7:0] CLASS_MASK = 8'hC0;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;
  localparam logic [7:0] ID_CLASS   = 8'h40;
  localparam logic [7:0] LEN_CLASS  = 8'h80;

  localparam logic [7:0] TYPE_OPEN  = 8'd5;
  localparam logic [7:0] TYPE_STOP  = 8'd6;
  localparam logic [7:0] TYPE_LAST  = 8'd7;
  localparam logic [7:0] TYPE_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]          outcome;
    logic [OUT_BITS-1:0] region_start;
    logic [OUT_BITS-1:0] region_length;
  } result_t;

endpackage

@@ src/rsrl_in_if.sv @@
// Image byte channel.
interface rsrl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rom_byte;
  logic       last_byte;

  modport source (output valid, output rom_byte, output last_byte, input ready);
  modport sink (input valid, input rom_byte, input last_byte, output ready);
endinterface

@@ src/rsrl_out_if.sv @@
// Result channel.
interface rsrl_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    outcome;
  logic [rsrl_pkg::OUT_BITS-1:0] region_start;
  logic [rsrl_pkg::OUT_BITS-1:0] region_length;

  modport source (output valid, output outcome, output region_start,
                  output region_length, input ready);
  modport sink (input valid, input outcome, input region_start,
                input region_length, output ready);
endinterface

@@ src/rsrl_parser.sv @@
// Parse state and single-byte step logic of the song region locator.
module rsrl_parser #(
  parameter int POSITION_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rom_byte,
  input  logic                last_byte,
  output rsrl_pkg::result_t   result
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_ID     = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_LEN_LO = 3'd4;
  localparam logic [2:0] PH_SKIP   = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam int PB = POSITION_BITS;
  localparam int OB = rsrl_pkg::OUT_BITS;

  logic [PB-1:0] pos, pos_next;
  logic [2:0]    phase, phase_next;
  logic          header_ok, header_ok_next;
  logic [7:0]    type_counter, type_counter_next;
  logic [22:0]   skip_remaining, skip_remaining_next;
  logic [13:0]   length_high_bits, length_high_bits_next;
  logic [PB-1:0] region_begin, region_begin_next;
  logic [PB-1:0] region_end, region_end_next;
  logic          end_captured, end_captured_next;
  logic          region_found, region_found_next;

  logic [PB-1:0]    count;
  logic [8:0]       type_sum;
  logic [7:0]       type_new;
  logic [PB-1:0]    stop_pos;
  logic [PB-1:0]    span;
  logic [PB+OB-1:0] count_wide;
  logic [PB+OB-1:0] begin_wide;
  logic [PB+OB-1:0] span_wide;

  always_comb begin
    pos_next              = pos;
    phase_next            = phase;
    header_ok_next        = header_ok;
    type_counter_next     = type_counter;
    skip_remaining_next   = skip_remaining;
    length_high_bits_next = length_high_bits;
    region_begin_next     = region_begin;
    region_end_next       = region_end;
    end_captured_next     = end_captured;
    region_found_next     = region_found;

    count    = pos + {{(PB-1){1'b0}}, 1'b1};
    type_sum = {1'b0, type_counter} + {1'b0, rom_byte};
    type_new = type_sum[8] ? 8'hFF : type_sum[7:0];

    case (phase)
      PH_HEADER: begin
        if (rom_byte != rsrl_pkg::MAGIC[pos[1:0]]) begin
          header_ok_next = 1'b0;
        end
        if (pos[1:0] == 2'd3) begin
          phase_next = header_ok_next ? PH_CMD : PH_DONE;
        end
      end
      PH_CMD: begin
        if (rom_byte == 8'h00) begin
          phase_next = PH_DONE;
        end else if ((rom_byte & rsrl_pkg::CLASS_MASK) == 8'h00) begin
          if (!region_found) begin
            if (type_new == rsrl_pkg::TYPE_OPEN) begin
              region_found_next = 1'b1;
              region_begin_next = count;
            end else if (type_new == rsrl_pkg::TYPE_STOP) begin
              phase_next = PH_DONE;
            end
          end else if (type_new > rsrl_pkg::TYPE_LAST) begin
            region_end_next   = pos;
            end_captured_next = 1'b1;
            phase_next        = PH_DONE;
          end
          type_counter_next = type_new;
        end else if ((rom_byte & rsrl_pkg::CLASS_MASK) == rsrl_pkg::ID_CLASS) begin
          phase_next = PH_ID;
        end else if ((rom_byte & rsrl_pkg::CLASS_MASK) == rsrl_pkg::LEN_CLASS) begin
          length_high_bits_next = {8'h00, rom_byte[5:0] & rsrl_pkg::LOW6_MASK[5:0]};
          phase_next            = PH_LEN_HI;
        end else begin
          region_found_next = 1'b0;
          phase_next        = PH_DONE;
        end
      end
      PH_ID: begin
        phase_next = PH_CMD;
      end
      PH_LEN_HI: begin
        length_high_bits_next = {length_high_bits[5:0], rom_byte};
        phase_next            = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        skip_remaining_next = {1'b0, length_high_bits, rom_byte} + 23'd1;
        phase_next          = PH_SKIP;
      end
      PH_SKIP: begin
        if (skip_remaining != 23'd0) begin
          skip_remaining_next = skip_remaining - 23'd1;
        end
        if (skip_remaining_next == 23'd0) begin
          phase_next = PH_CMD;
        end
      end
      default: begin
      end
    endcase

    pos_next = count;

    stop_pos   = end_captured_next ? region_end_next : count;
    span       = stop_pos - region_begin_next;
    count_wide = {{OB{1'b0}}, count};
    begin_wide = {{OB{1'b0}}, region_begin_next};
    span_wide  = {{OB{1'b0}}, span};

    if (!header_ok_next || phase_next == PH_HEADER) begin
      result.outcome       = rsrl_pkg::OUTCOME_WHOLE;
      result.region_start  = '0;
      result.region_length = count_wide[OB-1:0];
    end else if (region_found_next) begin
      result.outcome       = rsrl_pkg::OUTCOME_FOUND;
      result.region_start  = begin_wide[OB-1:0];
      result.region_length = span_wide[OB-1:0];
    end else begin
      result.outcome       = rsrl_pkg::OUTCOME_NO_REGION;
      result.region_start  = '0;
      result.region_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      pos          <= '0;
      phase        <= PH_HEADER;
      header_ok    <= 1'b1;
      type_counter <= rsrl_pkg::TYPE_RESET;
      end_captured <= 1'b0;
      region_found <= 1'b0;
    end else if (step) begin
      pos          <= pos_next;
      phase        <= phase_next;
      header_ok    <= header_ok_next;
      type_counter <= type_counter_next;
      end_captured <= end_captured_next;
      region_found <= region_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      skip_remaining   <= skip_remaining_next;
      length_high_bits <= length_high_bits_next;
      region_begin     <= region_begin_next;
      region_end       <= region_end_next;
    end
  end

endmodule

@@ src/rom_song_region_locator_top.sv @@
// Top level of the song region locator: input register, parser, result register.
// An accepted byte waits in the input register and is parsed when it is consumed; the
// result beat of a last byte is registered in the result register at its consumption.
// Throughput: one image byte per cycle unless stalled; the parse step is combinational.
// A held result stalls input only when the registered byte is also a last byte.
// Synchronous reset returns the parser to the header phase and empties both registers.
`include "rom_song_region_locator_top_defines.svh"

module rom_song_region_locator_top #(
  parameter int POSITION_BITS = 24
) (
  input logic           clk,
  input logic           rst,
  rsrl_in_if.sink       image,
  rsrl_out_if.source    result
);

  logic                in_full;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                consume;
  logic                out_valid;
  rsrl_pkg::result_t   out_data;
  rsrl_pkg::result_t   step_result;

  assign consume     = in_full && (!in_last || !out_valid || result.ready);
  assign image.ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (image.ready) begin
      in_full <= image.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (image.ready && image.valid) begin
      in_byte <= image.rom_byte;
      in_last <= image.last_byte;
    end
  end

  rsrl_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (consume),
    .rom_byte  (in_byte),
    .last_byte (in_last),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && in_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      out_data <= step_result;
    end
  end

  assign result.valid         = out_valid;
  assign result.outcome       = out_data.outcome;
  assign result.region_start  = out_data.region_start;
  assign result.region_length = out_data.region_length;

  `RSRL_ASSERT_NEXT(a_last_held, in_full && in_last && out_valid && !result.ready, in_full && in_last)
  `RSRL_ASSERT_SAME(a_no_region_zero, out_valid && out_data.outcome == rsrl_pkg::OUTCOME_NO_REGION, out_data.region_start == '0 && out_data.region_length == '0)
  `RSRL_ASSERT_SAME(a_whole_start_zero, out_valid && out_data.outcome == rsrl_pkg::OUTCOME_WHOLE, out_data.region_start == '0)

endmodule
